// ----- src/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

    // Result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Master-side tdata: 114 field bits padded to whole bytes
    localparam int unsigned FIELD_W = 114;
    localparam int unsigned TDATA_W = 120;
    localparam int unsigned PAD_W   = TDATA_W - FIELD_W;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_HEADER     = 2'd0;
    localparam kind_t KIND_PAYLOAD    = 2'd1;
    localparam kind_t KIND_INCOMPLETE = 2'd2;

    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [3:0]  header_bytes;
        logic [31:0] mask_key;
        logic [7:0]  payload_byte;
        logic        last;
    } wsd_result_t;

    // Up to two result words raised by one input word, oldest in first
    typedef struct packed {
        logic [1:0]  count;
        wsd_result_t first;
        wsd_result_t second;
    } wsd_push_t;

endpackage

`default_nettype wire

// ----- src/wsd_parser.sv -----
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    output wsd_push_t       push
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [6:0] CODE_LEN16 = 7'd126;
    localparam logic [6:0] CODE_LEN64 = 7'd127;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [6:0]  length_code_reg, length_code_next;
    logic [63:0] length_accum_reg, length_accum_next;
    logic [31:0] key_accum_reg, key_accum_next;
    logic        fin_flag_reg, fin_flag_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_flag_reg, mask_flag_next;
    logic [63:0] payload_left_reg, payload_left_next;

    logic        do_finish;
    logic        empty;
    logic [3:0]  ext_len;
    logic [3:0]  hdr_total;
    logic [63:0] left_dec;
    wsd_result_t res_main;
    wsd_result_t res_inc;
    logic        has_main;

    function automatic logic [3:0] ext_bytes(input logic [6:0] code);
        case (code)
            CODE_LEN16: ext_bytes = 4'd2;
            CODE_LEN64: ext_bytes = 4'd8;
            default:    ext_bytes = 4'd0;
        endcase
    endfunction

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        length_code_next  = length_code_reg;
        length_accum_next = length_accum_reg;
        key_accum_next    = key_accum_reg;
        fin_flag_next     = fin_flag_reg;
        opcode_next       = opcode_reg;
        mask_flag_next    = mask_flag_reg;
        payload_left_next = payload_left_reg;
        do_finish         = 1'b0;
        has_main          = 1'b0;
        res_main          = '0;
        res_inc           = '0;
        left_dec          = payload_left_reg - 64'd1;
        ext_len           = ext_bytes(length_code_reg);
        hdr_total         = 4'd2 + ext_len + (mask_flag_reg ? 4'd4 : 4'd0);

        case (phase_reg)
            PH_SECOND:
            begin
                mask_flag_next    = data_byte[7];
                length_code_next  = data_byte[6:0];
                header_count_next = 4'd2;
                length_accum_next = '0;
                key_accum_next    = '0;
                if (data_byte[6:0] == CODE_LEN16 || data_byte[6:0] == CODE_LEN64)
                begin
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    length_accum_next = {57'd0, data_byte[6:0]};
                    if (data_byte[7])
                        phase_next = PH_KEY;
                    else
                        do_finish = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                length_accum_next = {length_accum_reg[55:0], data_byte};
                header_count_next = header_count_reg + 4'd1;
                if (header_count_next >= 4'd2 + ext_len)
                begin
                    if (mask_flag_reg)
                        phase_next = PH_KEY;
                    else
                        do_finish = 1'b1;
                end
            end
            PH_KEY:
            begin
                key_accum_next    = {key_accum_reg[23:0], data_byte};
                header_count_next = header_count_reg + 4'd1;
                if (header_count_next >= hdr_total)
                    do_finish = 1'b1;
            end
            PH_PAYLOAD:
            begin
                payload_left_next     = left_dec;
                has_main              = 1'b1;
                res_main.kind         = KIND_PAYLOAD;
                res_main.payload_byte = data_byte;
                res_main.last         = (left_dec == 64'd0);
                if (left_dec == 64'd0)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                fin_flag_next     = data_byte[7];
                opcode_next       = data_byte[3:0];
                header_count_next = 4'd1;
                length_code_next  = '0;
                length_accum_next = '0;
                key_accum_next    = '0;
                mask_flag_next    = 1'b0;
                payload_left_next = '0;
                phase_next        = PH_SECOND;
            end
        endcase

        // Header complete: emit the header word, then payload or back to idle
        empty = (length_accum_next == 64'd0);
        if (do_finish)
        begin
            has_main                = 1'b1;
            res_main.kind           = KIND_HEADER;
            res_main.fin            = fin_flag_next;
            res_main.opcode         = opcode_next;
            res_main.masked         = mask_flag_next;
            res_main.payload_length = length_accum_next;
            res_main.header_bytes   = 4'd2 + ext_bytes(length_code_next)
                                      + (mask_flag_next ? 4'd4 : 4'd0);
            res_main.mask_key       = mask_flag_next ? key_accum_next : 32'd0;
            res_main.last           = empty;
            if (empty)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                payload_left_next = length_accum_next;
                phase_next        = PH_PAYLOAD;
            end
        end

        res_inc.kind = KIND_INCOMPLETE;
        res_inc.last = 1'b1;

        push.count  = 2'd0;
        push.first  = res_main;
        push.second = res_inc;
        if (end_of_data && phase_next != PH_IDLE)
        begin
            phase_next        = PH_IDLE;
            header_count_next = '0;
            payload_left_next = '0;
            if (has_main)
            begin
                push.count = 2'd2;
            end
            else
            begin
                push.count = 2'd1;
                push.first = res_inc;
            end
        end
        else if (has_main)
        begin
            push.count = 2'd1;
        end

        if (!step)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            header_count_reg <= '0;
            length_code_reg  <= '0;
            length_accum_reg <= '0;
            key_accum_reg    <= '0;
            fin_flag_reg     <= 1'b0;
            opcode_reg       <= '0;
            mask_flag_reg    <= 1'b0;
            payload_left_reg <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            length_code_reg  <= length_code_next;
            length_accum_reg <= length_accum_next;
            key_accum_reg    <= key_accum_next;
            fin_flag_reg     <= fin_flag_next;
            opcode_reg       <= opcode_next;
            mask_flag_reg    <= mask_flag_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/wsd_out_fifo.sv -----
`default_nettype none

module wsd_out_fifo
    import wsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire wsd_push_t push,
    output logic       space_two,
    output logic       out_valid,
    input  wire logic  out_ready,
    output wsd_result_t out_data
);

    wsd_result_t mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_two = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + (pop ? FIFO_PTR_W'(1) : FIFO_PTR_W'(0));
        count_next  = count_reg + FIFO_CNT_W'(push.count)
                      - (pop ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/websocket_frame_deframer_top.sv -----
// A result word reaches the master side through the input register, then the
// header/payload logic writing the result queue.
// Throughput: one input word per cycle while the result queue has room for two words;
// an end-of-data word inside a frame raises up to two result words.
// Reset: asynchronous, active low; the parser returns to idle awaiting a first header
// byte, and the input register and result queue are emptied.
`default_nettype none

module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  wire logic               s_axis_tlast,   // end_of_data

    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [0] fin, [4:1] opcode, [5] masked, [69:6] payload_length,
    // [73:70] header_bytes, [105:74] mask_key, [113:106] payload_byte, [119:114] zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]              m_axis_tuser,   // [1:0] kind
    output logic                    m_axis_tlast    // last
);

    // Input register: holds one byte until the result queue has room for
    // the worst case of two result words
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eod_reg;

    logic        space_two;
    logic        consume;
    wsd_push_t   push;
    wsd_result_t head;

    assign consume       = in_valid_reg && space_two;
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; load on every accepted word
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eod_reg  <= s_axis_tlast;
        end
    end

    // Header parse / payload count, advanced once per consumed byte
    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (consume),
        .data_byte   (in_byte_reg),
        .end_of_data (in_eod_reg),
        .push        (push)
    );

    // Result queue: decouples a stalled master side from the byte stream
    wsd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_two (space_two),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    // Pack the result word, first field lowest
    assign m_axis_tdata = {PAD_W'(0), head.payload_byte, head.mask_key, head.header_bytes,
                           head.payload_length, head.masked, head.opcode, head.fin};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ----- tb/websocket_frame_deframer_top_test.sv -----
`timescale 1ns / 100ps

module websocket_frame_deframer_top_test;

    import wsd_pkg::*;

    // Length codes that pull in an extended length field
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // A few frame opcodes for the directed frames
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] OP_MAX    = 4'hF;

    // Flow-control phases: who idles, and how often (percent of cycles)
    localparam int RATE_RX_SLOW = 0;    // sender idles 33, receiver idles 88
    localparam int RATE_TX_SLOW = 1;    // sender idles 88, receiver idles 33
    localparam int RATE_FULL    = 2;    // neither side idles

    localparam int TOTAL_WORDS  = 1400;
    localparam int HOLD_CYCLES  = 60;   // one long receiver hold-off
    localparam int DRAIN_CYCLES = 20;   // settle time once nothing is expected

    int unsigned tx_gap_pct [3] = '{33, 88, 0};
    int unsigned rx_gap_pct [3] = '{88, 33, 0};

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        FIRST_BYTE,
        SECOND_BYTE,
        EXT_LENGTH,
        MASK_KEY,
        PAYLOAD
    } parse_phase_t;

    // One input word waiting to be offered, tagged with its flow-control phase
    typedef struct {
        logic [7:0] data;
        logic       eod;
        int         rate;
    } stream_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;      // [7:0] data_byte
    logic                   s_axis_tlast = 1'b0;    // end_of_data

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] fin, [4:1] opcode, [5] masked, [69:6] payload_length,
    // [73:70] header_bytes, [105:74] mask_key, [113:106] payload_byte, [119:114] zero
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic [1:0]             m_axis_tuser;           // [1:0] kind
    logic                   m_axis_tlast;           // last

    stream_word_t           frame_bytes[$];         // bytes still to be offered
    wsd_result_t            expected_results[$];    // deframed words still owed by the block

    int                     words_queued = 0;
    int                     rx_rate = RATE_RX_SLOW;
    bit                     rx_hold = 1'b0;
    bit                     in_fire = 1'b0;

    int                     mismatches = 0;
    int                     bytes_taken = 0;
    int                     headers_seen = 0;
    int                     payload_seen = 0;
    int                     truncated_seen = 0;

    // Predictor state
    parse_phase_t           parse_phase = FIRST_BYTE;
    logic [3:0]             hdr_count = '0;
    logic [6:0]             len_code = '0;
    logic [63:0]            len_acc = '0;
    logic [31:0]            key_acc = '0;
    logic                   fin_bit = 1'b0;
    logic [3:0]             opcode_bits = '0;
    logic                   mask_bit = 1'b0;
    logic [63:0]            bytes_left = '0;

    websocket_frame_deframer_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Frame parser predictor
    // ------------------------------------------------------------------

    // Extended length bytes implied by the current length code
    function automatic int ext_len_bytes();
        if (len_code == LEN_CODE_16)
            return 2;
        if (len_code == LEN_CODE_64)
            return 8;
        return 0;
    endfunction

    function automatic int frame_hdr_bytes();
        return 2 + ext_len_bytes() + (mask_bit ? 4 : 0);
    endfunction

    // Header complete: emit the header word, then either go idle on an empty
    // payload or arm the payload countdown
    task automatic close_header();
        wsd_result_t hdr;
        hdr                = '0;
        hdr.kind           = KIND_HEADER;
        hdr.fin            = fin_bit;
        hdr.opcode         = opcode_bits;
        hdr.masked         = mask_bit;
        hdr.payload_length = len_acc;
        hdr.header_bytes   = 4'(frame_hdr_bytes());
        hdr.mask_key       = mask_bit ? key_acc : '0;
        hdr.last           = (len_acc == '0);
        expected_results.push_back(hdr);
        if (len_acc == '0)
            parse_phase = FIRST_BYTE;
        else
        begin
            bytes_left  = len_acc;
            parse_phase = PAYLOAD;
        end
    endtask

    // Advance the parser by one stream byte and queue whatever it produces
    task automatic deframe_byte(input logic [7:0] b, input logic eod);
        wsd_result_t res;
        case (parse_phase)
            SECOND_BYTE:
            begin
                mask_bit  = b[7];
                len_code  = b[6:0];
                hdr_count = 4'd2;
                len_acc   = '0;
                key_acc   = '0;
                if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64)
                    parse_phase = EXT_LENGTH;
                else
                begin
                    len_acc = 64'(len_code);
                    if (mask_bit)
                        parse_phase = MASK_KEY;
                    else
                        close_header();
                end
            end
            EXT_LENGTH:
            begin
                len_acc   = {len_acc[55:0], b};
                hdr_count = hdr_count + 4'd1;
                if (int'(hdr_count) >= 2 + ext_len_bytes())
                begin
                    if (mask_bit)
                        parse_phase = MASK_KEY;
                    else
                        close_header();
                end
            end
            MASK_KEY:
            begin
                key_acc   = {key_acc[23:0], b};
                hdr_count = hdr_count + 4'd1;
                if (int'(hdr_count) >= frame_hdr_bytes())
                    close_header();
            end
            PAYLOAD:
            begin
                bytes_left       = bytes_left - 64'd1;
                res              = '0;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = b;
                res.last         = (bytes_left == '0);
                expected_results.push_back(res);
                if (bytes_left == '0)
                    parse_phase = FIRST_BYTE;
            end
            default:
            begin
                fin_bit     = b[7];
                opcode_bits = b[3:0];
                hdr_count   = 4'd1;
                len_code    = '0;
                len_acc     = '0;
                key_acc     = '0;
                mask_bit    = 1'b0;
                bytes_left  = '0;
                parse_phase = SECOND_BYTE;
            end
        endcase

        // Buffer ran dry mid-frame: flag the frame as cut short and drop it
        if (eod && parse_phase != FIRST_BYTE)
        begin
            res         = '0;
            res.kind    = KIND_INCOMPLETE;
            res.last    = 1'b1;
            expected_results.push_back(res);
            parse_phase = FIRST_BYTE;
            hdr_count   = '0;
            bytes_left  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic add_word(input logic [7:0] data, input logic eod, input int rate);
        stream_word_t w;
        w.data = data;
        w.eod  = eod;
        w.rate = rate;
        frame_bytes.push_back(w);
        words_queued++;
    endtask

    // Queue one frame. A short length code stands for the length itself.
    // cut >= 0 sends only the first cut bytes, the last of them flagged as
    // end of data; otherwise the whole frame goes out, with end of data on its
    // final byte if eod_end is set.
    task automatic add_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                             input logic msk, input logic [6:0] code, input logic [63:0] len,
                             input logic [31:0] key, input int cut, input logic eod_end,
                             input int rate);
        logic [7:0]        hdr[$];
        logic [63:0]       plen;
        longint unsigned   total;
        longint unsigned   sent;
        logic [7:0]        b;

        plen = len;
        hdr.push_back({fin, rsv, opc});
        hdr.push_back({msk, code});
        if (code == LEN_CODE_16)
        begin
            plen = {48'd0, len[15:0]};
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
        end
        else if (code == LEN_CODE_64)
        begin
            for (int i = 7; i >= 0; i--)
                hdr.push_back(len[i*8 +: 8]);
        end
        else
            plen = 64'(code);
        if (msk)
        begin
            for (int i = 3; i >= 0; i--)
                hdr.push_back(key[i*8 +: 8]);
        end

        total = longint'(hdr.size()) + plen;
        sent  = (cut >= 0 && longint'(cut) < total) ? longint'(cut) : total;
        for (longint unsigned i = 0; i < sent; i++)
        begin
            b = (i < longint'(hdr.size())) ? hdr[i] : 8'($urandom);
            add_word(b, (i == sent - 1) && (cut >= 0 || eod_end), rate);
        end
    endtask

    initial
    begin
        int          rate;
        int          pick;
        int          sel;
        int          hl;
        int          burst;
        logic        msk;
        logic [6:0]  code;
        logic [63:0] len;

        // Directed frames: empty payload, reserved bits, opcode and key all ones with
        // fin clear, empty extended-16 length, extended-64 length with its top bit set
        // and the buffer ending on the last length byte, buffer ending on the very
        // first byte, buffer ending exactly on the final byte of a frame
        add_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 7'd0, '0, '0, -1, 1'b0, RATE_RX_SLOW);
        add_frame(1'b0, 3'b111, OP_MAX, 1'b1, 7'd1, '0, 32'hFFFF_FFFF, -1, 1'b0,
                  RATE_RX_SLOW);
        add_frame(1'b1, 3'b000, OP_BINARY, 1'b0, LEN_CODE_16, '0, '0, -1, 1'b0,
                  RATE_RX_SLOW);
        add_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, LEN_CODE_64, 64'h8000_0000_0000_0001, '0,
                  10, 1'b0, RATE_RX_SLOW);
        add_frame(1'b1, 3'b000, OP_PING, 1'b0, 7'd5, '0, '0, 1, 1'b0, RATE_RX_SLOW);
        add_frame(1'b1, 3'b000, OP_PONG, 1'b0, 7'd1, '0, '0, -1, 1'b1, RATE_RX_SLOW);

        // Random traffic: mostly well-formed frames with random content, mixed with
        // frames cut short in the header or payload, and bursts of raw noise
        while (words_queued < TOTAL_WORDS)
        begin
            rate = (words_queued < TOTAL_WORDS / 3)     ? RATE_RX_SLOW :
                   (words_queued < 2 * TOTAL_WORDS / 3) ? RATE_TX_SLOW : RATE_FULL;
            pick = $urandom_range(99);
            sel  = $urandom_range(9);
            msk  = 1'($urandom_range(1));

            if (sel < 6)
            begin
                code = ($urandom_range(7) == 0) ? 7'($urandom_range(125))
                                                : 7'($urandom_range(12));
                len  = 64'(code);
            end
            else if (sel < 8)
            begin
                code = LEN_CODE_16;
                len  = ($urandom_range(9) == 0) ? 64'($urandom_range(300))
                                                : 64'($urandom_range(20));
            end
            else
            begin
                code = LEN_CODE_64;
                len  = 64'($urandom_range(16));
            end
            hl = 2 + (code == LEN_CODE_16 ? 2 : code == LEN_CODE_64 ? 8 : 0) + (msk ? 4 : 0);

            if (pick < 12)
            begin
                // Huge random length; the buffer ends up to four payload bytes in
                code = $urandom_range(1) ? LEN_CODE_64 : LEN_CODE_16;
                hl   = 2 + (code == LEN_CODE_16 ? 2 : 8) + (msk ? 4 : 0);
                len  = {32'($urandom), 32'($urandom)};
                add_frame(1'($urandom_range(1)), 3'($urandom), 4'($urandom), msk, code, len,
                          32'($urandom), hl + $urandom_range(4), 1'b0, rate);
            end
            else if (pick < 22)
                add_frame(1'($urandom_range(1)), 3'($urandom), 4'($urandom), msk, code, len,
                          32'($urandom), $urandom_range(hl, 1), 1'b0, rate);
            else if (pick < 26)
            begin
                // Noise burst, always closed by end of data to resync the parser
                burst = $urandom_range(12, 1);
                for (int i = 0; i < burst; i++)
                    add_word(8'($urandom), (i == burst - 1) || ($urandom_range(7) == 0),
                             rate);
            end
            else
                add_frame(1'($urandom_range(1)), 3'($urandom), 4'($urandom), msk, code, len,
                          32'($urandom), -1, $urandom_range(3) == 0, rate);
        end

        // Hold reset, then release away from the active edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (frame_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d stream bytes in; %0d headers, %0d payload bytes, %0d cut-short frames",
                 bytes_taken, headers_seen, payload_seen, truncated_seen);
        $display("flow phases covered: slow receiver, slow sender, full rate, long stall");
        if (mismatches == 0)
            $display("websocket_frame_deframer_top: match");
        else
            $display("websocket_frame_deframer_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Slave-side driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // Drop the word the block took at the last rising edge
            if (in_fire)
                void'(frame_bytes.pop_front());
            // Hold the current word until taken, otherwise pick the next one
            if (!s_axis_tvalid || in_fire)
            begin
                if (frame_bytes.size() != 0 &&
                    $urandom_range(99) >= tx_gap_pct[frame_bytes[0].rate])
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= frame_bytes[0].data;
                    s_axis_tlast  <= frame_bytes[0].eod;
                    rx_rate       <= frame_bytes[0].rate;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Master-side ready: random back-pressure, or the forced long hold-off
    always @(negedge clk)
    begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_gap_pct[rx_rate]);
    end

    // Once the full-rate phase begins, starve the output long enough for the
    // result queue to fill and the input to stall while the sender keeps offering
    initial
    begin
        while (rx_rate != RATE_FULL)
            @(posedge clk);
        repeat (50) @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, check outputs, feed the predictor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        wsd_result_t want;
        wsd_result_t got;
        if (!rst_n)
            in_fire = 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind           = m_axis_tuser;
                got.fin            = m_axis_tdata[0];
                got.opcode         = m_axis_tdata[4:1];
                got.masked         = m_axis_tdata[5];
                got.payload_length = m_axis_tdata[69:6];
                got.header_bytes   = m_axis_tdata[73:70];
                got.mask_key       = m_axis_tdata[105:74];
                got.payload_byte   = m_axis_tdata[113:106];
                got.last           = m_axis_tlast;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %0h",
                             $realtime, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(got.kind));
                    check_field("fin", 64'(want.fin), 64'(got.fin));
                    check_field("opcode", 64'(want.opcode), 64'(got.opcode));
                    check_field("masked", 64'(want.masked), 64'(got.masked));
                    check_field("payload_length", want.payload_length, got.payload_length);
                    check_field("header_bytes", 64'(want.header_bytes),
                                64'(got.header_bytes));
                    check_field("mask_key", 64'(want.mask_key), 64'(got.mask_key));
                    check_field("payload_byte", 64'(want.payload_byte),
                                64'(got.payload_byte));
                    check_field("last", 64'(want.last), 64'(got.last));
                    check_field("pad", '0, 64'(m_axis_tdata[TDATA_W-1:FIELD_W]));
                    if (want.kind == KIND_HEADER)
                        headers_seen++;
                    else if (want.kind == KIND_PAYLOAD)
                        payload_seen++;
                    else
                        truncated_seen++;
                end
            end

            // Advance the predictor on every byte the block accepts
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire)
            begin
                bytes_taken++;
                deframe_byte(s_axis_tdata, s_axis_tlast);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("websocket_frame_deframer_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/wsd_pkg.sv
src/wsd_parser.sv
src/wsd_out_fifo.sv
src/websocket_frame_deframer_top.sv
tb/websocket_frame_deframer_top_test.sv
